### design/ptd_pkg.sv
package ptd_pkg;

	localparam int TASK_SLOTS_DEF = 8;

	localparam int BASE_W   = 16;
	localparam int TIME_W   = 32;
	localparam int OP_W     = 3;
	localparam int ID_W     = 8;
	localparam int TASK_W   = 7;
	localparam int KIND_W   = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W    = 32;

	localparam logic [BASE_W-1:0] BASE_TICK_RESET = 16'd100;
	localparam logic [TIME_W-1:0] TIMEOUT_RESET   = 32'd10000;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_TICK = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_TICK       = 3'd0,
		OP_REGISTER   = 3'd1,
		OP_STOP       = 3'd2,
		OP_START      = 3'd3,
		OP_SET_PERIOD = 3'd4
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_DISPATCH = 2'd0,
		KIND_TICK_END = 2'd1,
		KIND_ANSWER   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_DIV,
		ST_ANSWER,
		ST_SCAN_RD,
		ST_SCAN_EVAL,
		ST_TICK_END
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic in_ready;
		logic answer;
		logic scan_eval;
		logic tick_end;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_valid;
		op_t  op;
		logic div_done;
		logic live_ok;
		logic out_free;
		logic emit_due;
		logic scan_last;
	} ctrl_sts_t;

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
			input logic [BASE_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {{(TIME_W-BASE_W+1){1'b0}}, b};
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

endpackage

### design/ptd_channels.sv
interface ptd_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [7:0]  task_id;
	logic [31:0] period_ms;

	modport source (output valid, output op, output task_id, output period_ms, input ready);
	modport sink (input valid, input op, input task_id, input period_ms, output ready);
endinterface

interface ptd_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [6:0] task_no;
	logic       ok;
	logic       last;

	modport source (output valid, output kind, output task_no, output ok, output last,
		input ready);
	modport sink (input valid, input kind, input task_no, input ok, input last,
		output ready);
endinterface

### design/periodic_task_dispatcher.sv
// tick: when the run is live, one table read and one evaluate per slot, then
// the tick-end result; when timed out, the tick-end result alone. Register and
// set period wait on the bit-serial remainder unit checking period against base
// tick; stop, start and unknown ops answer straight after decode. One item in
// flight at a time, plus a waiting result in the output register. Async
// active-low reset clears the slot flags, ring pointer and run time and restores
// the config defaults; the period/elapsed rams need no clear.
module periodic_task_dispatcher #(
	parameter int TASK_SLOTS = ptd_pkg::TASK_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ptd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ptd_pkg::CFG_W-1:0]     cfg_data,
	ptd_req_if.sink                       req,
	ptd_rsp_if.source                     rsp
);

	import ptd_pkg::*;

	// control/status handoff between sequencer and datapath
	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	// sequencer: decode, wait on remainder unit, walk the slot table, emit results
	ptd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// datapath: config regs, slot table, run time, remainder unit, output register
	ptd_datapath #(.TASK_SLOTS(TASK_SLOTS)) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.rsp       (rsp)
	);

endmodule

### design/ptd_ram.sv
module ptd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### design/ptd_rem.sv
module ptd_rem (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic        zero
);

	logic [15:0] rem_q;
	logic [31:0] dvd_q;
	logic [5:0]  cnt_q;
	logic [16:0] trial;
	logic [16:0] diff;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, dvd_q[31]};
	assign diff  = trial - {1'b0, divisor};
	assign done  = cnt_q[5];
	assign zero  = (rem_q == 16'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd32;
		end else if (start) begin
			cnt_q <= 6'd0;
		end else if (!done) begin
			cnt_q <= cnt_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 16'd0;
			dvd_q <= dividend;
		end else if (!done) begin
			rem_q <= (trial >= {1'b0, divisor}) ? diff[15:0] : trial[15:0];
			dvd_q <= {dvd_q[30:0], 1'b0};
		end
	end

endmodule

### design/ptd_datapath.sv
module ptd_datapath #(
	parameter int TASK_SLOTS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ptd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ptd_pkg::CFG_W-1:0]     cfg_data,
	input  ptd_pkg::ctrl_cmd_t            cmd,
	output ptd_pkg::ctrl_sts_t            sts,
	ptd_req_if.sink                       req,
	ptd_rsp_if.source                     rsp
);

	import ptd_pkg::*;

	localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam logic [SW-1:0] LAST_SLOT = SW'(TASK_SLOTS - 1);

	logic [BASE_W-1:0] base_q;
	logic [TIME_W-1:0] timeout_q;
	logic [TIME_W-1:0] run_q;

	op_t               op_q;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] per_q;

	logic [TASK_SLOTS-1:0] valid_q;
	logic [TASK_SLOTS-1:0] stopped_q;
	logic [SW-1:0]         next_q;
	logic [SW-1:0]         idx_q;

	logic              out_valid_q;
	kind_t             kind_q;
	logic [TASK_W-1:0] task_q;
	logic              ok_q;
	logic              last_q;

	logic              take;
	logic              div_done;
	logic              rem_zero;
	logic              fits;
	logic              id_ok;
	logic [SW-1:0]     id_slot;
	logic [TIME_W-1:0] per_rd;
	logic [TIME_W-1:0] el_rd;
	logic              due;

	logic              per_we;
	logic [SW-1:0]     per_waddr;
	logic              el_we;
	logic [SW-1:0]     el_waddr;
	logic [TIME_W-1:0] el_wdata;

	logic              ans_ok;
	logic [TASK_W-1:0] ans_task;
	logic              load;
	kind_t             load_kind;
	logic [TASK_W-1:0] load_task;
	logic              load_ok;
	logic              load_last;

	assign take      = req.valid && req.ready;
	assign req.ready = cmd.in_ready;

	assign fits    = (base_q != '0) && rem_zero;
	assign id_ok   = (id_q != '0) && (id_q <= ID_W'(TASK_SLOTS));
	assign id_slot = SW'(id_q - ID_W'(1));
	assign due     = valid_q[idx_q] && !stopped_q[idx_q] && (el_rd >= per_rd);

	assign sts.in_valid  = req.valid;
	assign sts.op        = op_q;
	assign sts.div_done  = div_done;
	assign sts.live_ok   = (run_q < timeout_q);
	assign sts.out_free  = !out_valid_q || rsp.ready;
	assign sts.emit_due  = due;
	assign sts.scan_last = (idx_q == LAST_SLOT);

	ptd_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (take),
		.dividend (req.period_ms),
		.divisor  (base_q),
		.done     (div_done),
		.zero     (rem_zero)
	);

	ptd_ram #(.WIDTH(TIME_W), .DEPTH(TASK_SLOTS), .AW(SW)) u_period_ram (
		.clk   (clk),
		.we    (per_we),
		.waddr (per_waddr),
		.wdata (per_q),
		.raddr (idx_q),
		.rdata (per_rd)
	);

	ptd_ram #(.WIDTH(TIME_W), .DEPTH(TASK_SLOTS), .AW(SW)) u_elapsed_ram (
		.clk   (clk),
		.we    (el_we),
		.waddr (el_waddr),
		.wdata (el_wdata),
		.raddr (idx_q),
		.rdata (el_rd)
	);

	// command answers and table writes
	always_comb begin
		ans_ok    = 1'b0;
		ans_task  = '0;
		per_we    = 1'b0;
		per_waddr = next_q;
		el_we     = 1'b0;
		el_waddr  = idx_q;
		el_wdata  = due ? TIME_W'(base_q) : sat_add(el_rd, base_q);
		unique case (op_q)
			OP_REGISTER: begin
				ans_ok   = fits;
				ans_task = fits ? (TASK_W'(next_q) + TASK_W'(1)) : '0;
				per_we   = cmd.answer && fits;
				el_we    = cmd.answer && fits;
				el_waddr = next_q;
				el_wdata = per_q;
			end
			OP_STOP, OP_START: begin
				ans_ok = id_ok;
			end
			OP_SET_PERIOD: begin
				ans_ok    = id_ok && fits;
				per_we    = cmd.answer && id_ok && fits;
				per_waddr = id_slot;
			end
			OP_TICK: begin
				el_we = cmd.scan_eval && valid_q[idx_q];
			end
			default: begin
				ans_ok = 1'b0;
			end
		endcase
	end

	// result selection for the output register
	always_comb begin
		load      = cmd.answer || cmd.tick_end || (cmd.scan_eval && due);
		load_kind = KIND_DISPATCH;
		load_task = TASK_W'(idx_q) + TASK_W'(1);
		load_ok   = 1'b1;
		load_last = 1'b0;
		if (cmd.answer) begin
			load_kind = KIND_ANSWER;
			load_task = ans_task;
			load_ok   = ans_ok;
			load_last = 1'b1;
		end else if (cmd.tick_end) begin
			load_kind = KIND_TICK_END;
			load_task = '0;
			load_ok   = sts.live_ok;
			load_last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= BASE_TICK_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE_TICK: base_q    <= cfg_data[BASE_W-1:0];
				REG_TIMEOUT:   timeout_q <= cfg_data[TIME_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_q  <= op_t'(req.op);
			id_q  <= req.task_id;
			per_q <= req.period_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			stopped_q <= '0;
			next_q    <= '0;
			run_q     <= '0;
			idx_q     <= '0;
		end else begin
			if (take) begin
				idx_q <= '0;
			end else if (cmd.scan_eval && idx_q != LAST_SLOT) begin
				idx_q <= idx_q + SW'(1);
			end
			if (cmd.tick_end && sts.live_ok) begin
				run_q <= sat_add(run_q, base_q);
			end
			if (cmd.answer) begin
				if (op_q == OP_REGISTER && fits) begin
					valid_q[next_q]   <= 1'b1;
					stopped_q[next_q] <= 1'b0;
					next_q            <= (next_q == LAST_SLOT) ? '0 : next_q + SW'(1);
				end else if ((op_q == OP_STOP || op_q == OP_START) && id_ok) begin
					stopped_q[id_slot] <= (op_q == OP_STOP);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= load_kind;
			task_q <= load_task;
			ok_q   <= load_ok;
			last_q <= load_last;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.kind    = kind_q;
	assign rsp.task_no = task_q;
	assign rsp.ok      = ok_q;
	assign rsp.last    = last_q;

endmodule

### design/ptd_ctrl.sv
module ptd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  ptd_pkg::ctrl_sts_t sts,
	output ptd_pkg::ctrl_cmd_t cmd
);

	import ptd_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   eval_go;

	assign eval_go = sts.out_free || !sts.emit_due;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sts.in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				priority case (sts.op)
					OP_TICK:                    state_d = sts.live_ok ? ST_SCAN_RD : ST_TICK_END;
					OP_REGISTER, OP_SET_PERIOD: state_d = ST_DIV;
					default:                    state_d = ST_ANSWER;
				endcase
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_d = ST_ANSWER;
				end
			end
			ST_ANSWER: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN_RD: begin
				state_d = ST_SCAN_EVAL;
			end
			ST_SCAN_EVAL: begin
				if (eval_go) begin
					state_d = sts.scan_last ? ST_TICK_END : ST_SCAN_RD;
				end
			end
			ST_TICK_END: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:      cmd.in_ready  = 1'b1;
			ST_ANSWER:    cmd.answer    = sts.out_free;
			ST_SCAN_EVAL: cmd.scan_eval = eval_go;
			ST_TICK_END:  cmd.tick_end  = sts.out_free;
			default:      cmd           = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import ptd_pkg::*;

	localparam int SLOTS = TASK_SLOTS_DEF;
	// no accepted item on either channel for this long means the block hung
	localparam int STALL_LIMIT = 2000;
	// longer than a register pass, so this covers any straggler
	localparam int SETTLE_CYCLES = 40;
	// cycles the receiver holds off in the back-pressure test
	localparam int LONG_HOLD = 150;
	localparam int RANDOM_PER_PHASE = 45;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [ID_W-1:0]   task_id;
		logic [TIME_W-1:0] period_ms;
	} sched_cmd_t;

	typedef struct {
		kind_t             kind;
		logic [TASK_W-1:0] task_no;
		logic              ok;
		logic              last;
	} sched_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	ptd_req_if req();
	ptd_rsp_if rsp();

	periodic_task_dispatcher uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.rsp       (rsp)
	);

	// mirror of the task table and run clock
	logic              tab_valid   [SLOTS];
	logic [TIME_W-1:0] tab_period  [SLOTS];
	logic [TIME_W-1:0] tab_elapsed [SLOTS];
	logic              tab_stopped [SLOTS];
	int                tab_next;
	logic [TIME_W-1:0] tab_run_time;
	logic [BASE_W-1:0] tab_base;
	logic [TIME_W-1:0] tab_timeout;

	// scheduler results still owed by the block, oldest first
	sched_result_t sched_results[$];

	int mismatches;
	bit src_idle_on;
	bit rsp_idle_on;
	int hold_left;
	int stall_left;

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// mirror of the scheduler
	// ---------------------------------------------------------------

	function automatic void mirror_reset();
		for (int i = 0; i < SLOTS; i++) begin
			tab_valid[i]   = 1'b0;
			tab_period[i]  = '0;
			tab_elapsed[i] = '0;
			tab_stopped[i] = 1'b0;
		end
		tab_next     = 0;
		tab_run_time = '0;
		tab_base     = BASE_TICK_RESET;
		tab_timeout  = TIMEOUT_RESET;
	endfunction

	// time counters stick at all ones instead of wrapping
	function automatic logic [TIME_W-1:0] add_capped(input logic [TIME_W-1:0] a,
			input logic [BASE_W-1:0] b);
		if (a > {TIME_W{1'b1}} - TIME_W'(b))
			return {TIME_W{1'b1}};
		return a + TIME_W'(b);
	endfunction

	// a zero base tick accepts no period at all
	function automatic bit period_on_grid(input logic [TIME_W-1:0] p);
		return tab_base != '0 && (p % TIME_W'(tab_base)) == '0;
	endfunction

	// apply one accepted command to the mirror and queue what it should produce
	function automatic void sched_step(input sched_cmd_t c);
		sched_result_t outs [SLOTS+1];
		int            n;
		bit            id_ok;
		int            slot;

		n     = 0;
		id_ok = c.task_id >= 1 && c.task_id <= SLOTS;
		case (c.op)
			OP_TICK: begin
				if (tab_run_time < tab_timeout) begin
					for (int i = 0; i < SLOTS; i++) begin
						if (tab_valid[i] && !tab_stopped[i] && tab_elapsed[i] >= tab_period[i]) begin
							outs[n] = '{KIND_DISPATCH, TASK_W'(i + 1), 1'b1, 1'b0};
							n++;
							tab_elapsed[i] = '0;
						end
						// unregistered slots stay frozen
						if (tab_valid[i])
							tab_elapsed[i] = add_capped(tab_elapsed[i], tab_base);
					end
					tab_run_time = add_capped(tab_run_time, tab_base);
					outs[n] = '{KIND_TICK_END, '0, 1'b1, 1'b0};
				end else begin
					// timed out: nothing moves
					outs[n] = '{KIND_TICK_END, '0, 1'b0, 1'b0};
				end
				n++;
			end
			OP_REGISTER: begin
				if (period_on_grid(c.period_ms)) begin
					slot = tab_next;
					tab_valid[slot]   = 1'b1;
					tab_period[slot]  = c.period_ms;
					tab_elapsed[slot] = c.period_ms;
					tab_stopped[slot] = 1'b0;
					tab_next = (slot + 1) % SLOTS;
					outs[n] = '{KIND_ANSWER, TASK_W'(slot + 1), 1'b1, 1'b0};
				end else begin
					outs[n] = '{KIND_ANSWER, '0, 1'b0, 1'b0};
				end
				n++;
			end
			OP_STOP, OP_START: begin
				if (id_ok)
					tab_stopped[c.task_id - 1] = (c.op == OP_STOP);
				outs[n] = '{KIND_ANSWER, '0, id_ok, 1'b0};
				n++;
			end
			OP_SET_PERIOD: begin
				// elapsed time is kept as it is
				if (id_ok && period_on_grid(c.period_ms)) begin
					tab_period[c.task_id - 1] = c.period_ms;
					outs[n] = '{KIND_ANSWER, '0, 1'b1, 1'b0};
				end else begin
					outs[n] = '{KIND_ANSWER, '0, 1'b0, 1'b0};
				end
				n++;
			end
			default: begin
				outs[n] = '{KIND_ANSWER, '0, 1'b0, 1'b0};
				n++;
			end
		endcase
		for (int k = 0; k < n; k++) begin
			outs[k].last = (k == n - 1);
			sched_results.push_back(outs[k]);
		end
	endfunction

	// ---------------------------------------------------------------
	// channel drivers
	// ---------------------------------------------------------------

	// offer one command and wait for it to be taken; valid is left high so that
	// back-to-back commands see no bubble
	task automatic send_cmd(input sched_cmd_t c);
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req.valid     <= 1'b1;
		req.op        <= c.op;
		req.task_id   <= c.task_id;
		req.period_ms <= c.period_ms;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		sched_step(c);
	endtask

	task automatic send_fields(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
			input logic [TIME_W-1:0] period);
		sched_cmd_t c;
		c = '{op, id, period};
		send_cmd(c);
	endtask

	// sender pauses until every owed result has come back
	task automatic drain();
		req.valid <= 1'b0;
		while (sched_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// both registers in back-to-back writes; upper bits of the base write are junk
	// that the block must drop
	task automatic set_config(input logic [BASE_W-1:0] base, input logic [TIME_W-1:0] limit);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_BASE_TICK;
		cfg_data  <= {BASE_W'($urandom()), base};
		@(posedge clk);
		cfg_index <= REG_TIMEOUT;
		cfg_data  <= limit;
		@(posedge clk);
		cfg_we   <= 1'b0;
		tab_base    = base;
		tab_timeout = limit;
	endtask

	// mostly well-formed commands on the current base grid, some noise
	function automatic sched_cmd_t random_cmd();
		sched_cmd_t c;
		int         pick;
		pick        = $urandom_range(0, 99);
		c.task_id   = ID_W'($urandom_range(1, SLOTS));
		c.period_ms = TIME_W'(tab_base) * $urandom_range(0, 6);
		if (pick < 40)
			c.op = OP_TICK;
		else if (pick < 60)
			c.op = OP_REGISTER;
		else if (pick < 70)
			c.op = OP_STOP;
		else if (pick < 80)
			c.op = OP_START;
		else if (pick < 88)
			c.op = OP_SET_PERIOD;
		else begin
			c.op        = OP_W'($urandom_range(0, 7));
			c.task_id   = ID_W'($urandom_range(0, 255));
			c.period_ms = $urandom();
		end
		return c;
	endfunction

	// receiver: long hold when asked, else random stall bursts while idling is enabled
	always @(posedge clk) begin
		if (hold_left > 0) begin
			rsp.ready <= 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			rsp.ready <= 1'b0;
			stall_left--;
		end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
			rsp.ready <= 1'b0;
			stall_left = $urandom_range(0, 4);
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------
	// result checking
	// ---------------------------------------------------------------

	task automatic note_mismatch(input string what);
		mismatches++;
		$display("%0t mismatch: %s", $realtime, what);
	endtask

	always @(posedge clk) begin
		sched_result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (sched_results.size() == 0) begin
				note_mismatch($sformatf("unexpected result kind %0d task %0d ok %0b last %0b",
					rsp.kind, rsp.task_no, rsp.ok, rsp.last));
			end else begin
				want = sched_results.pop_front();
				if (rsp.kind !== want.kind)
					note_mismatch($sformatf("kind %0d, want %0d", rsp.kind, want.kind));
				if (rsp.task_no !== want.task_no)
					note_mismatch($sformatf("task_no %0d, want %0d", rsp.task_no, want.task_no));
				if (rsp.ok !== want.ok)
					note_mismatch($sformatf("ok %b, want %b (kind %0d)", rsp.ok, want.ok, want.kind));
				if (rsp.last !== want.last)
					note_mismatch($sformatf("last %b, want %b", rsp.last, want.last));
			end
		end
	end

	// hang detector
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// reset config: register on and off the grid, first ticks dispatch at once
	task automatic test_reset_dispatch();
		send_fields(OP_REGISTER, 8'd0, 32'd100);
		send_fields(OP_REGISTER, 8'd0, 32'd150);
		send_fields(OP_TICK, 8'd0, 32'd0);
		send_fields(OP_TICK, 8'd0, 32'd0);
	endtask

	// task number range, unregistered slots, set period grid, unknown ops
	task automatic test_command_checks();
		send_fields(OP_STOP, 8'd0, 32'd0);
		send_fields(OP_STOP, 8'(SLOTS + 1), 32'd0);
		send_fields(OP_START, 8'hFF, 32'hFFFF_FFFF);
		send_fields(OP_SET_PERIOD, 8'd0, 32'd200);
		// last slot was never registered but still takes stop and start
		send_fields(OP_STOP, 8'(SLOTS), 32'd0);
		send_fields(OP_START, 8'(SLOTS), 32'd0);
		send_fields(OP_SET_PERIOD, 8'd1, 32'd300);
		send_fields(OP_SET_PERIOD, 8'd1, 32'd301);
		for (int k = OP_SET_PERIOD + 1; k < (1 << OP_W); k++)
			send_fields(OP_W'(k), 8'($urandom()), $urandom());
		send_fields(OP_TICK, 8'd0, 32'd0);
	endtask

	// zero base tick: nothing fits the grid and ticks move no clock
	task automatic test_zero_base();
		set_config('0, {TIME_W{1'b1}});
		send_fields(OP_REGISTER, 8'd0, 32'd0);
		send_fields(OP_SET_PERIOD, 8'd1, 32'd0);
		send_fields(OP_TICK, 8'd0, 32'd0);
	endtask

	// timeout at zero, then a window that closes after two ticks
	task automatic test_timed_out();
		set_config(16'd100, '0);
		send_fields(OP_TICK, 8'd0, 32'd0);
		set_config(16'd100, tab_run_time + 32'd200);
		repeat (3) send_fields(OP_TICK, 8'd0, 32'd0);
	endtask

	// widest base and an all-ones period: a stopped slot's elapsed time sticks at
	// all ones and dispatches once restarted
	task automatic test_saturation();
		logic [ID_W-1:0] id;
		set_config({BASE_W{1'b1}}, {TIME_W{1'b1}});
		id = ID_W'(tab_next + 1);
		send_fields(OP_REGISTER, 8'd0, {TIME_W{1'b1}});
		send_fields(OP_STOP, id, 32'd0);
		send_fields(OP_TICK, 8'd0, 32'd0);
		send_fields(OP_START, id, 32'd0);
		send_fields(OP_TICK, 8'd0, 32'd0);
	endtask

	// random traffic over several base ticks; the last phase gets a timeout that its ticks can run into
	task automatic test_random_phases();
		logic [BASE_W-1:0] base;
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: base = 16'd1;
				1: base = BASE_TICK_RESET;
				2: base = BASE_W'($urandom_range(2, 65534));
				3: base = {BASE_W{1'b1}};
				default: base = BASE_W'($urandom_range(1, 300));
			endcase
			if (phase == 4)
				set_config(base, tab_run_time + TIME_W'(base) * $urandom_range(10, 25));
			else
				set_config(base, {TIME_W{1'b1}});
			repeat (RANDOM_PER_PHASE) send_cmd(random_cmd());
		end
	endtask

	// receiver holds off while the sender keeps offering, so the block backs up;
	// then the sender waits for everything to come back
	task automatic test_output_hold();
		set_config(BASE_W'($urandom_range(1, 1000)), {TIME_W{1'b1}});
		src_idle_on = 1'b0;
		@(posedge clk);
		hold_left = LONG_HOLD;
		repeat (20) send_cmd(random_cmd());
		src_idle_on = 1'b1;
		drain();
	endtask

	// closing stretch with no idling on either side
	task automatic test_steady_stream();
		set_config(BASE_W'($urandom_range(1, 65535)), {TIME_W{1'b1}});
		src_idle_on = 1'b0;
		rsp_idle_on = 1'b0;
		repeat (50) send_cmd(random_cmd());
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_BASE_TICK;
		cfg_data      = '0;
		req.valid     = 1'b0;
		req.op        = OP_TICK;
		req.task_id   = '0;
		req.period_ms = '0;
		rsp.ready     = 1'b0;
		mismatches    = 0;
		hold_left     = 0;
		stall_left    = 0;
		src_idle_on   = 1'b1;
		rsp_idle_on   = 1'b1;
		mirror_reset();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_dispatch();
		test_command_checks();
		test_zero_base();
		test_timed_out();
		test_saturation();
		test_random_phases();
		test_output_hold();
		test_steady_stream();

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && sched_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
